/* hdl/y2p_pkg.sv */
// ----------------------------------------------------------------------------
// y2p_pkg
// Shared types and constants for the YUYV 4:2:2 to planar 4:2:0 converter.
// ----------------------------------------------------------------------------
package y2p_pkg;

	localparam int OFF_W      = 23;
	localparam int LUMA_OFF_W = 22;
	localparam int CHR_OFF_W  = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int PAIRS_W    = 11;
	localparam int ROWS_W     = 12;

	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_PAIRS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd1;

	localparam logic [PAIRS_W-1:0] PAIRS_RESET = 11'd320;
	localparam logic [ROWS_W-1:0]  ROWS_RESET  = 12'd480;

	localparam logic [1:0] PLANE_Y = 2'd0;
	localparam logic [1:0] PLANE_U = 2'd1;
	localparam logic [1:0] PLANE_V = 2'd2;

	localparam logic [1:0] BEAT_Y0 = 2'd0;
	localparam logic [1:0] BEAT_Y1 = 2'd1;
	localparam logic [1:0] BEAT_U  = 2'd2;
	localparam logic [1:0] BEAT_V  = 2'd3;

	typedef struct packed {
		logic [7:0]            y0;
		logic [7:0]            y1;
		logic [7:0]            u_avg;
		logic [7:0]            v_avg;
		logic [LUMA_OFF_W-1:0] luma_off;
		logic [OFF_W-1:0]      u_off;
		logic [OFF_W-1:0]      v_off;
		logic                  odd_row;
		logic                  frame_end;
	} cmd_t;

endpackage

/* hdl/y2p_front.sv */
// ----------------------------------------------------------------------------
// y2p_front
// Accepts pixel pairs, tracks frame position, keeps the chroma line buffer
// and builds one write command record per pair for the queue.
// ----------------------------------------------------------------------------
module y2p_front #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [31:0]                    s_tdata,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [y2p_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [y2p_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [y2p_pkg::QCNT_W-1:0]     q_count,
	output logic                           push,
	output y2p_pkg::cmd_t                  push_cmd
);

	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int COL_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int PAIR_W     = $clog2(LINE_DEPTH + 1);
	localparam int RCNT_W     = $clog2(MAX_HEIGHT + 1);
	localparam int PROD_W     = PAIR_W + RCNT_W;

	logic [y2p_pkg::PAIRS_W-1:0]    pairs_q;
	logic [y2p_pkg::ROWS_W-1:0]     rows_q;
	logic [PAIR_W-1:0]              eff_pairs;
	logic [RCNT_W-1:0]              eff_rows;
	logic [PROD_W-1:0]              prod_all_q;
	logic [PROD_W-1:0]              prod_c_q;
	logic [y2p_pkg::OFF_W-1:0]      y_size_q;
	logic [y2p_pkg::OFF_W-1:0]      yc_size_q;
	logic [1:0]                     settle_q;

	logic [COL_W-1:0]               col_q;
	logic [ROW_W-1:0]               row_q;
	logic [y2p_pkg::LUMA_OFF_W-1:0] luma_q;
	logic [y2p_pkg::CHR_OFF_W-1:0]  chroma_q;

	logic [15:0]                    line_mem [LINE_DEPTH];

	logic                           valid_s1;
	logic [15:0]                    rd_s1;
	logic [7:0]                     y0_s1;
	logic [7:0]                     y1_s1;
	logic [7:0]                     u_s1;
	logic [7:0]                     v_s1;
	logic [y2p_pkg::LUMA_OFF_W-1:0] luma_s1;
	logic [y2p_pkg::OFF_W-1:0]      u_off_s1;
	logic [y2p_pkg::OFF_W-1:0]      v_off_s1;
	logic                           odd_s1;
	logic                           fend_s1;

	logic                           accept;
	logic                           cfg_hit;
	logic                           odd_row;
	logic                           last_col;
	logic                           last_row;
	logic                           last_pair;
	logic [y2p_pkg::QCNT_W:0]       occupancy;
	logic [8:0]                     u_sum;
	logic [8:0]                     v_sum;

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index == y2p_pkg::CFG_PAIRS ||
		cfg_index == y2p_pkg::CFG_ROWS);

	always_comb begin
		if (pairs_q == '0) begin
			eff_pairs = PAIR_W'(1);
		end else if (32'(pairs_q) > LINE_DEPTH) begin
			eff_pairs = PAIR_W'(LINE_DEPTH);
		end else begin
			eff_pairs = PAIR_W'(pairs_q);
		end
		if (32'(rows_q) < 2) begin
			eff_rows = RCNT_W'(2);
		end else if (32'(rows_q) > MAX_HEIGHT) begin
			eff_rows = RCNT_W'(MAX_HEIGHT);
		end else begin
			eff_rows = RCNT_W'(rows_q);
		end
	end

	assign occupancy = {1'b0, q_count} + (y2p_pkg::QCNT_W + 1)'(valid_s1);
	assign s_tready  = (settle_q == 2'd0) && (32'(occupancy) < y2p_pkg::QDEPTH);
	assign accept    = s_tvalid && s_tready;

	assign odd_row   = row_q[0];
	assign last_col  = (32'(col_q) + 32'd1) >= 32'(eff_pairs);
	assign last_row  = (32'(row_q) + 32'd1) >= 32'(eff_rows);
	assign last_pair = last_row && last_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pairs_q  <= y2p_pkg::PAIRS_RESET;
			rows_q   <= y2p_pkg::ROWS_RESET;
			settle_q <= 2'd2;
		end else begin
			if (cfg_valid && cfg_index == y2p_pkg::CFG_PAIRS) begin
				pairs_q <= cfg_data[y2p_pkg::PAIRS_W-1:0];
			end
			if (cfg_valid && cfg_index == y2p_pkg::CFG_ROWS) begin
				rows_q <= cfg_data[y2p_pkg::ROWS_W-1:0];
			end
			if (cfg_valid) begin
				settle_q <= 2'd2;
			end else if (settle_q != 2'd0) begin
				settle_q <= settle_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_all_q <= PROD_W'(eff_pairs) * PROD_W'(eff_rows);
		prod_c_q   <= PROD_W'(eff_pairs) * PROD_W'(eff_rows >> 1);
		y_size_q   <= y2p_pkg::OFF_W'({prod_all_q, 1'b0});
		yc_size_q  <= y2p_pkg::OFF_W'({prod_all_q, 1'b0}) + y2p_pkg::OFF_W'(prod_c_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			luma_q   <= '0;
			chroma_q <= '0;
		end else if (cfg_hit) begin
			col_q    <= '0;
			row_q    <= '0;
			luma_q   <= '0;
			chroma_q <= '0;
		end else if (accept) begin
			if (last_pair) begin
				col_q    <= '0;
				row_q    <= '0;
				luma_q   <= '0;
				chroma_q <= '0;
			end else begin
				luma_q <= luma_q + y2p_pkg::LUMA_OFF_W'(2);
				if (odd_row) begin
					chroma_q <= chroma_q + y2p_pkg::CHR_OFF_W'(1);
				end
				if (last_col) begin
					col_q <= '0;
					row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (!odd_row && !last_row) begin
				line_mem[col_q] <= {s_tdata[31:24], s_tdata[15:8]};
			end
			rd_s1 <= line_mem[col_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			y0_s1    <= s_tdata[7:0];
			u_s1     <= s_tdata[15:8];
			y1_s1    <= s_tdata[23:16];
			v_s1     <= s_tdata[31:24];
			luma_s1  <= luma_q;
			u_off_s1 <= y_size_q + y2p_pkg::OFF_W'(chroma_q);
			v_off_s1 <= yc_size_q + y2p_pkg::OFF_W'(chroma_q);
			odd_s1   <= odd_row;
			fend_s1  <= last_pair;
		end
	end

	assign u_sum = {1'b0, u_s1} + {1'b0, rd_s1[7:0]};
	assign v_sum = {1'b0, v_s1} + {1'b0, rd_s1[15:8]};

	assign push = valid_s1;

	always_comb begin
		push_cmd.y0        = y0_s1;
		push_cmd.y1        = y1_s1;
		push_cmd.u_avg     = u_sum[8:1];
		push_cmd.v_avg     = v_sum[8:1];
		push_cmd.luma_off  = luma_s1;
		push_cmd.u_off     = u_off_s1;
		push_cmd.v_off     = v_off_s1;
		push_cmd.odd_row   = odd_s1;
		push_cmd.frame_end = fend_s1;
	end

endmodule

/* hdl/y2p_queue.sv */
// ----------------------------------------------------------------------------
// y2p_queue
// Small command queue between the front stage and the write sequencer.
// ----------------------------------------------------------------------------
module y2p_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  y2p_pkg::cmd_t              push_cmd,
	input  logic                       pop,
	output y2p_pkg::cmd_t              head,
	output logic                       empty,
	output logic [y2p_pkg::QCNT_W-1:0] count
);

	y2p_pkg::cmd_t                slots [y2p_pkg::QDEPTH];
	logic [y2p_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [y2p_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [y2p_pkg::QCNT_W-1:0]   count_q;

	assign head  = slots[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + y2p_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + y2p_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + y2p_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - y2p_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

/* hdl/y2p_back.sv */
// ----------------------------------------------------------------------------
// y2p_back
// Steps through each queued command, two or four byte writes, into the
// output register.
// ----------------------------------------------------------------------------
module y2p_back (
	input  logic          clk,
	input  logic          arst_n,
	input  y2p_pkg::cmd_t head,
	input  logic          empty,
	output logic          pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [31:0]   m_tdata,
	output logic          m_tlast,
	output logic [2:0]    m_tuser
);

	logic [1:0]                beat_q;
	logic                      valid_q;
	logic [1:0]                plane_q;
	logic [y2p_pkg::OFF_W-1:0] offset_q;
	logic [7:0]                sample_q;
	logic                      last_q;
	logic                      fend_q;

	logic                      load;
	logic                      last_beat;
	logic [1:0]                plane_d;
	logic [y2p_pkg::OFF_W-1:0] offset_d;
	logic [7:0]                sample_d;

	assign load      = !empty && (!valid_q || m_tready);
	assign last_beat = head.odd_row ? (beat_q == y2p_pkg::BEAT_V) :
		(beat_q == y2p_pkg::BEAT_Y1);
	assign pop       = load && last_beat;

	always_comb begin
		case (beat_q)
			y2p_pkg::BEAT_Y0: begin
				plane_d  = y2p_pkg::PLANE_Y;
				offset_d = y2p_pkg::OFF_W'(head.luma_off);
				sample_d = head.y0;
			end
			y2p_pkg::BEAT_Y1: begin
				plane_d  = y2p_pkg::PLANE_Y;
				offset_d = y2p_pkg::OFF_W'(head.luma_off) + y2p_pkg::OFF_W'(1);
				sample_d = head.y1;
			end
			y2p_pkg::BEAT_U: begin
				plane_d  = y2p_pkg::PLANE_U;
				offset_d = head.u_off;
				sample_d = head.u_avg;
			end
			default: begin
				plane_d  = y2p_pkg::PLANE_V;
				offset_d = head.v_off;
				sample_d = head.v_avg;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q  <= y2p_pkg::BEAT_Y0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				beat_q  <= last_beat ? y2p_pkg::BEAT_Y0 : beat_q + 2'd1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			plane_q  <= plane_d;
			offset_q <= offset_d;
			sample_q <= sample_d;
			last_q   <= last_beat;
			fend_q   <= last_beat && head.frame_end;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {1'b0, sample_q, offset_q};
	assign m_tlast  = last_q;
	assign m_tuser  = {fend_q, plane_q};

endmodule

/* hdl/yuyv_to_planar_420.sv */
// ----------------------------------------------------------------------------
// yuyv_to_planar_420
// Converts a packed YUYV 4:2:2 pixel-pair stream into byte write commands
// that build a planar 4:2:0 frame (Y plane, then U, then V).
//
// Input stream: one pixel pair per transaction in raster order.
// Output stream: one byte write per transaction; each pair gives Y0, Y1 and,
// on odd rows, the averaged U and V. tlast marks the final write of a pair,
// tuser bit 2 the final write of the frame.
// Config channel: index 0 pairs per row, index 1 row count; any such write
// restarts the frame. Write only while the block is idle.
// Flow: a taken pair is registered in the front stage, then written into
// the command queue, from which its byte writes load the output register.
// Throughput: the output port moves one byte per cycle while the receiver is
// ready, so a pair takes two byte writes on even rows and four on odd rows;
// pairs enter every cycle while the four-entry command queue has room.
// Reset: counters clear, registers load 320 and 480, the line buffer holds
// whatever it held. Input is held off after reset and after a config write
// while the plane sizes are recomputed.
// Stall: a stalled receiver holds the output register, the queue fills and
// s_tready drops; nothing is dropped.
// ----------------------------------------------------------------------------
module yuyv_to_planar_420 #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [31:0]                    s_tdata,   // luma_first, chroma_blue, luma_second, chroma_red
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [31:0]                    m_tdata,   // byte_offset[22:0], sample[30:23], zero
	output logic                           m_tlast,
	output logic [2:0]                     m_tuser,   // plane[1:0], frame_end[2]
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [y2p_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [y2p_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic                       push;
	y2p_pkg::cmd_t              push_cmd;
	logic                       pop;
	y2p_pkg::cmd_t              head;
	logic                       empty;
	logic [y2p_pkg::QCNT_W-1:0] q_count;

	y2p_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_count   (q_count),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	y2p_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.count    (q_count)
	);

	y2p_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// YUYV 4:2:2 to planar 4:2:0 converter testbench
// Streams pixel pairs into the converter under random valid and ready gaps.
// A behavioral predictor of the frame counters and the chroma line buffer
// builds the expected byte writes, and every output transaction is checked
// in order against them. A directed table covers reset values, register
// extremes and saturation, odd row counts and the frame wrap. Random phases
// with mostly small frames follow.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int                            PAIR_TARGET = 310;
	localparam int                            DRAIN_GAP   = 8;
	localparam logic [y2p_pkg::CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

	typedef struct packed {
		logic [7:0] chroma_red;
		logic [7:0] luma_second;
		logic [7:0] chroma_blue;
		logic [7:0] luma_first;
	} pixel_pair_t;

	typedef struct packed {
		logic [1:0]                plane;
		logic [y2p_pkg::OFF_W-1:0] offset;
		logic [7:0]                sample;
		logic                      last;
		logic                      fend;
	} byte_write_t;

	typedef struct packed {
		logic                           is_reg;
		logic [y2p_pkg::CFG_IDX_W-1:0]  idx;
		logic [y2p_pkg::CFG_DATA_W-1:0] val;
		pixel_pair_t                    pix;
		logic                           typed;
		logic [y2p_pkg::OFF_W-1:0]      off;
		logic                           fend;
	} step_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [31:0]                    s_tdata   = '0;
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [31:0]                    m_tdata;
	logic                           m_tlast;
	logic [2:0]                     m_tuser;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [y2p_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [y2p_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	logic                           no_idle   = 1'b0;
	int                             errors    = 0;

	logic [y2p_pkg::PAIRS_W-1:0]    pairs_reg;
	logic [y2p_pkg::ROWS_W-1:0]     rows_reg;
	logic [15:0]                    chroma_line [1024];
	logic [9:0]                     pair_col;
	logic [10:0]                    row_idx;
	logic [y2p_pkg::LUMA_OFF_W-1:0] luma_off;
	logic [y2p_pkg::CHR_OFF_W-1:0]  chroma_off;

	byte_write_t                    pending_writes [$];
	step_t                          directed [$];

	yuyv_to_planar_420 dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= no_idle || ($urandom_range(99) >= 16);
	end

	function automatic void restart_frame();
		pair_col   = '0;
		row_idx    = '0;
		luma_off   = '0;
		chroma_off = '0;
	endfunction

	function automatic void apply_reg(logic [y2p_pkg::CFG_IDX_W-1:0] idx,
			logic [y2p_pkg::CFG_DATA_W-1:0] val);
		if (idx == y2p_pkg::CFG_PAIRS) begin
			pairs_reg = val[y2p_pkg::PAIRS_W-1:0];
			restart_frame();
		end else if (idx == y2p_pkg::CFG_ROWS) begin
			rows_reg = val[y2p_pkg::ROWS_W-1:0];
			restart_frame();
		end
	endfunction

	function automatic void convert_pair(pixel_pair_t p, output byte_write_t w[4], output int n);
		int unsigned ppr, rows, col, y_size, c_size;
		logic [15:0] saved;
		bit          last_row, last_pair;
		ppr       = (pairs_reg == 0) ? 1 : (pairs_reg > 1024) ? 1024 : pairs_reg;
		rows      = (rows_reg < 2) ? 2 : (rows_reg > 2048) ? 2048 : rows_reg;
		col       = pair_col % ppr;
		y_size    = 2 * ppr * rows;
		c_size    = ppr * (rows / 2);
		last_row  = row_idx >= rows - 1;
		last_pair = last_row && (pair_col >= ppr - 1);
		w[0] = '{y2p_pkg::PLANE_Y, y2p_pkg::OFF_W'(luma_off), p.luma_first, 1'b0, 1'b0};
		w[1] = '{y2p_pkg::PLANE_Y, y2p_pkg::OFF_W'(luma_off) + 1'b1, p.luma_second,
			1'b0, 1'b0};
		n = 2;
		if (row_idx[0]) begin
			saved = chroma_line[col];
			w[2] = '{y2p_pkg::PLANE_U, y2p_pkg::OFF_W'(y_size + chroma_off),
				8'((9'(p.chroma_blue) + 9'(saved[7:0])) >> 1), 1'b0, 1'b0};
			w[3] = '{y2p_pkg::PLANE_V, y2p_pkg::OFF_W'(y_size + c_size + chroma_off),
				8'((9'(p.chroma_red) + 9'(saved[15:8])) >> 1), 1'b0, 1'b0};
			n = 4;
			chroma_off = chroma_off + 1'b1;
		end else if (!last_row) begin
			chroma_line[col] = {p.chroma_red, p.chroma_blue};
		end
		w[n-1].last = 1'b1;
		if (last_pair) begin
			w[n-1].fend = 1'b1;
			restart_frame();
		end else begin
			luma_off = luma_off + 2'd2;
			if (pair_col >= ppr - 1) begin
				pair_col = '0;
				row_idx  = row_idx + 1'b1;
			end else begin
				pair_col = pair_col + 1'b1;
			end
		end
	endfunction

	function automatic step_t pair_row(logic [7:0] y0, logic [7:0] u, logic [7:0] y1,
			logic [7:0] v, logic typed, logic [y2p_pkg::OFF_W-1:0] off, logic fend);
		return '{1'b0, '0, '0, '{v, y1, u, y0}, typed, off, fend};
	endfunction

	function automatic step_t reg_row(logic [y2p_pkg::CFG_IDX_W-1:0] idx,
			logic [y2p_pkg::CFG_DATA_W-1:0] val);
		return '{1'b1, idx, val, '0, 1'b0, '0, 1'b0};
	endfunction

	task automatic note_error(string what, byte_write_t want, byte_write_t got);
		string want_s;
		string got_s;
		errors++;
		if (errors <= 10) begin
			want_s = $sformatf("plane %0d off %0d sample %02h last %0b fend %0b",
				want.plane, want.offset, want.sample, want.last, want.fend);
			got_s  = $sformatf("plane %0d off %0d sample %02h last %0b fend %0b",
				got.plane, got.offset, got.sample, got.last, got.fend);
			$display("%0t %s: expected %s, got %s", $realtime, what, want_s, got_s);
		end
	endtask

	always @(posedge clk) begin
		byte_write_t got;
		byte_write_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tuser[1:0], m_tdata[22:0], m_tdata[30:23], m_tlast, m_tuser[2]};
			if (pending_writes.size() == 0) begin
				note_error("unexpected write", '0, got);
			end else begin
				want = pending_writes.pop_front();
				if (got !== want)
					note_error("write mismatch", want, got);
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_pair(pixel_pair_t p, logic typed, logic [y2p_pkg::OFF_W-1:0] off,
			logic fend);
		byte_write_t w[4];
		int          n;
		while (!no_idle && $urandom_range(99) < 16) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= p;
		do @(posedge clk); while (!s_tready);
		convert_pair(p, w, n);
		if (typed) begin
			pending_writes.push_back('{y2p_pkg::PLANE_Y, off, p.luma_first, 1'b0, 1'b0});
			pending_writes.push_back('{y2p_pkg::PLANE_Y, off + 1'b1, p.luma_second,
				1'b1, fend});
		end else begin
			for (int i = 0; i < n; i++)
				pending_writes.push_back(w[i]);
		end
		@(negedge clk);
	endtask

	task automatic write_reg(logic [y2p_pkg::CFG_IDX_W-1:0] idx,
			logic [y2p_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, val);
		@(negedge clk);
	endtask

	// Hold input until all writes are out; optionally let the pipeline settle.
	task automatic drain(bit settle);
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_writes.size() != 0)
			@(negedge clk);
		if (settle)
			repeat (DRAIN_GAP) @(negedge clk);
	endtask

	initial begin
		#5ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		bit                             in_cfg;
		int                             sent;
		int                             phase;
		int                             n;
		logic [y2p_pkg::CFG_DATA_W-1:0] pv;
		logic [y2p_pkg::CFG_DATA_W-1:0] rv;

		directed.push_back(pair_row(8'h00, 8'h00, 8'hFF, 8'hFF, 1'b1, y2p_pkg::OFF_W'(0), 1'b0));
		directed.push_back(pair_row(8'hFF, 8'hFF, 8'h00, 8'h00, 1'b1, y2p_pkg::OFF_W'(2), 1'b0));
		directed.push_back(reg_row(y2p_pkg::CFG_PAIRS, 12'd1));
		directed.push_back(reg_row(y2p_pkg::CFG_ROWS, 12'd3));
		directed.push_back(pair_row(8'h12, 8'hFF, 8'h34, 8'hFF, 1'b1, y2p_pkg::OFF_W'(0), 1'b0));
		directed.push_back(pair_row(8'h56, 8'hFF, 8'h78, 8'hFF, 1'b0, y2p_pkg::OFF_W'(0), 1'b0));
		directed.push_back(pair_row(8'h9A, 8'h00, 8'hBC, 8'h00, 1'b1, y2p_pkg::OFF_W'(4), 1'b1));
		directed.push_back(pair_row(8'h01, 8'hFF, 8'h02, 8'h00, 1'b1, y2p_pkg::OFF_W'(0), 1'b0));
		directed.push_back(pair_row(8'h03, 8'h00, 8'h04, 8'hFF, 1'b0, y2p_pkg::OFF_W'(0), 1'b0));
		directed.push_back(pair_row(8'hFE, 8'h80, 8'hFD, 8'h81, 1'b1, y2p_pkg::OFF_W'(4), 1'b1));
		directed.push_back(reg_row(y2p_pkg::CFG_PAIRS, 12'd0));
		directed.push_back(reg_row(y2p_pkg::CFG_ROWS, 12'd0));
		directed.push_back(pair_row(8'h80, 8'h7F, 8'h7F, 8'h80, 1'b1, y2p_pkg::OFF_W'(0), 1'b0));
		directed.push_back(pair_row(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b0, y2p_pkg::OFF_W'(0), 1'b0));
		directed.push_back(reg_row(y2p_pkg::CFG_PAIRS, 12'hFFF));
		directed.push_back(reg_row(y2p_pkg::CFG_ROWS, 12'hFFF));
		directed.push_back(pair_row(8'h11, 8'h22, 8'h33, 8'h44, 1'b1, y2p_pkg::OFF_W'(0), 1'b0));
		directed.push_back(pair_row(8'h55, 8'h66, 8'h77, 8'h88, 1'b1, y2p_pkg::OFF_W'(2), 1'b0));
		directed.push_back(reg_row(CFG_UNUSED, 12'hFFF));
		directed.push_back(pair_row(8'h99, 8'hAA, 8'hBB, 8'hCC, 1'b1, y2p_pkg::OFF_W'(4), 1'b0));
		directed.push_back(reg_row(y2p_pkg::CFG_PAIRS, 12'd2));
		directed.push_back(reg_row(y2p_pkg::CFG_ROWS, 12'd1));
		directed.push_back(pair_row(8'h0F, 8'hF0, 8'h3C, 8'hC3, 1'b0, y2p_pkg::OFF_W'(0), 1'b0));
		directed.push_back(pair_row(8'hF0, 8'h0F, 8'hC3, 8'h3C, 1'b0, y2p_pkg::OFF_W'(0), 1'b0));
		directed.push_back(pair_row(8'h5A, 8'hA5, 8'h69, 8'h96, 1'b0, y2p_pkg::OFF_W'(0), 1'b0));
		directed.push_back(pair_row(8'hA5, 8'h5A, 8'h96, 8'h69, 1'b0, y2p_pkg::OFF_W'(0), 1'b0));
		directed.push_back(reg_row(y2p_pkg::CFG_PAIRS, 12'd1024));
		directed.push_back(reg_row(y2p_pkg::CFG_ROWS, 12'd2048));
		directed.push_back(pair_row(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1, y2p_pkg::OFF_W'(0), 1'b0));

		pairs_reg = y2p_pkg::PAIRS_RESET;
		rows_reg  = y2p_pkg::ROWS_RESET;
		restart_frame();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		in_cfg = 1'b0;
		sent   = 0;
		foreach (directed[i]) begin
			if (directed[i].is_reg) begin
				if (!in_cfg)
					drain(1'b1);
				in_cfg = 1'b1;
				write_reg(directed[i].idx, directed[i].val);
			end else begin
				if (in_cfg)
					cfg_valid <= 1'b0;
				in_cfg = 1'b0;
				send_pair(directed[i].pix, directed[i].typed, directed[i].off, directed[i].fend);
				sent++;
			end
		end

		phase = 0;
		while (sent < PAIR_TARGET) begin
			drain(1'b1);
			case ($urandom_range(9))
				0: begin
					pv = $urandom_range(1) ? 12'd0 : 12'($urandom_range(1024, 4095));
					rv = 12'($urandom_range(2, 5));
				end
				1: begin
					pv = 12'($urandom_range(1, 4));
					rv = $urandom_range(1) ? 12'($urandom_range(0, 1))
						: 12'($urandom_range(2048, 4095));
				end
				default: begin
					pv = 12'($urandom_range(1, 6));
					rv = 12'($urandom_range(2, 7));
				end
			endcase
			case ($urandom_range(3))
				0: write_reg(y2p_pkg::CFG_PAIRS, pv);
				1: write_reg(y2p_pkg::CFG_ROWS, rv);
				2: begin
					write_reg(y2p_pkg::CFG_ROWS, rv);
					write_reg(y2p_pkg::CFG_PAIRS, pv);
				end
				default: begin
					write_reg(y2p_pkg::CFG_PAIRS, pv);
					write_reg(y2p_pkg::CFG_ROWS, rv);
				end
			endcase
			cfg_valid <= 1'b0;
			n = $urandom_range(15, 45);
			for (int k = 0; k < n && sent < PAIR_TARGET; k++) begin
				if (phase == 1 && k == n / 2)
					drain(1'b0);
				no_idle <= (sent >= 120 && sent < 180);
				send_pair(pixel_pair_t'($urandom), 1'b0, '0, 1'b0);
				sent++;
			end
			phase++;
		end

		drain(1'b1);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
